[design/hrlp_pkg.sv]
`timescale 1ns / 1ps

package hrlp_pkg;

   // path limit in decoded bytes
   localparam int unsigned PATH_MAX_LEN = 128;
   localparam int unsigned PLEN_W = 8;

   // depth of the queue between front and back
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // number of known methods
   localparam int unsigned NMETH = 8;

   // special bytes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PCT   = 8'h25;

   // result kinds
   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // method codes
   localparam logic [3:0] METH_NONE = 4'd0;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_METH = 3'd1;
   localparam logic [2:0] ST_NO_SPACE = 3'd2;
   localparam logic [2:0] ST_NO_END   = 3'd3;
   localparam logic [2:0] ST_TOO_LONG = 3'd4;

   // candidate sets at the start of a request
   localparam logic [NMETH-1:0] CAND_BASIC = 8'h1F;
   localparam logic [NMETH-1:0] CAND_FULL  = 8'hFF;

   // method names, first character in the top byte, space padded
   localparam logic [6:0][7:0] METH_TEXT [NMETH] = '{
      "GET    ", "HEAD   ", "POST   ", "PUT    ",
      "DELETE ", "CONNECT", "OPTIONS", "TRACE  "
   };
   localparam logic [2:0] METH_LEN [NMETH] = '{
      3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5
   };

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_METHOD,
      PH_SPACE,
      PH_PATH,
      PH_DONE
   } phase_type;

   // one classified input word
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       is_space;
      logic       is_pct;
      logic [3:0] nibble;
   } cls_type;

   // character of a method name at a position, space past the name, zero at position seven
   function automatic logic [7:0] meth_char(input logic [2:0] idx, input logic [2:0] pos);
      logic [6:0][7:0] txt;
      logic [7:0]      ch;
      begin
         txt = METH_TEXT[idx];
         if (pos == 3'd7) begin
            ch = 8'h00;
         end else begin
            ch = txt[3'(3'd6 - pos)];
         end
         return ch;
      end
   endfunction

endpackage

[design/http_request_line_parser.sv]
`timescale 1ns / 1ps

// HTTP request line parser with percent decoding.
// Request bytes enter one word per cycle on the req_ queue port: a word is
// taken at a clock edge with req_push high and req_full low. req_first_byte
// starts a new request; req_buffer_end marks the last byte of the buffer.
// Results leave on the rsp_ queue port: while rsp_empty is low the oldest
// result is on the rsp_ ports and it is taken at an edge with rsp_pop high.
// Path bytes come out decoded (kind 0); each request ends with one outcome
// word (kind 1, rsp_last high) giving the method and status.
// The method set register is written on csr_ when csr_valid and csr_ready
// are high; it is read when a request starts and resets to the basic set.
// A result shows on the rsp_ ports once its byte has gone through the front
// queue and the parser has written it to the output register; it can be
// popped from then on.
// Throughput: one byte per cycle, set by the parser step in
// the back end, which consumes a queued byte whenever the output register
// is free or being popped in the same cycle.
// When rsp_pop is held low the four-entry front queue fills, then req_full
// rises. Reset empties the queue and output register and returns the parser
// to idle; bytes before the first req_first_byte are dropped.

module http_request_line_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_buffer_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_kind,
   output logic [7:0] rsp_path_char,
   output logic [3:0] rsp_method,
   output logic [2:0] rsp_status,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_full_method_set
);

   hrlp_pkg::cls_type wr_word;
   hrlp_pkg::cls_type rd_word;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   // byte classification
   hrlp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_buffer_end (req_buffer_end),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_word         (wr_word)
   );

   // decoupling queue
   hrlp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_word (wr_word),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_word (rd_word)
   );

   // parser and output register
   hrlp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_full_method_set (csr_full_method_set),
      .q_empty             (q_empty),
      .q_word              (rd_word),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_kind            (rsp_kind),
      .rsp_path_char       (rsp_path_char),
      .rsp_method          (rsp_method),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last)
   );

endmodule

[design/hrlp_front.sv]
`timescale 1ns / 1ps

module hrlp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_first_byte,
   input  logic             req_buffer_end,
   input  logic             q_full,
   output logic             q_push,
   output hrlp_pkg::cls_type q_word
);

   logic [3:0] nibble;
   logic       seen_ff;
   logic       seen_in;

   // hex digit value, anything else counts as zero
   always_comb begin
      nibble = 4'd0;
      if (req_data_byte inside {[8'h30:8'h39]}) begin
         nibble = 4'(req_data_byte - 8'h30);
      end else if (req_data_byte inside {[8'h41:8'h46]}) begin
         nibble = 4'(req_data_byte - 8'h37);
      end else if (req_data_byte inside {[8'h61:8'h66]}) begin
         nibble = 4'(req_data_byte - 8'h57);
      end
   end

   // classified word toward the queue
   always_comb begin
      q_word.data     = req_data_byte;
      q_word.first    = req_first_byte;
      q_word.last     = req_buffer_end;
      q_word.is_space = (req_data_byte == hrlp_pkg::CH_SPACE);
      q_word.is_pct   = (req_data_byte == hrlp_pkg::CH_PCT);
      q_word.nibble   = nibble;
   end

   // bytes before the first request start are dropped here
   assign req_full = q_full;
   assign q_push   = req_push && !q_full && (seen_ff || req_first_byte);
   assign seen_in  = seen_ff || (req_push && !q_full && req_first_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

[design/hrlp_queue.sv]
`timescale 1ns / 1ps

module hrlp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrlp_pkg::cls_type wr_word,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output hrlp_pkg::cls_type rd_word
);

   hrlp_pkg::cls_type                   slot_ff [hrlp_pkg::QDEPTH];
   logic [hrlp_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [hrlp_pkg::QPTR_W-1:0]         wr_ptr_in;
   logic [hrlp_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [hrlp_pkg::QPTR_W-1:0]         rd_ptr_in;
   logic [hrlp_pkg::QCNT_W-1:0]         cnt_ff;
   logic [hrlp_pkg::QCNT_W-1:0]         cnt_in;
   logic                                do_push;
   logic                                do_pop;

   assign full    = (cnt_ff == hrlp_pkg::QCNT_W'(hrlp_pkg::QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_word = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_word;
      end
   end

   // fill count never passes the depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= hrlp_pkg::QCNT_W'(hrlp_pkg::QDEPTH))
      else $error("queue count out of range");

   // count tracks pointer distance
   a_cnt_ptr: assert property (@(posedge clock) disable iff (reset)
      hrlp_pkg::QPTR_W'(cnt_ff) == hrlp_pkg::QPTR_W'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue count disagrees with pointers");

   // a push into a non-full queue makes it non-empty
   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      do_push |=> !empty)
      else $error("queue empty after push");

endmodule

[design/hrlp_back.sv]
`timescale 1ns / 1ps

module hrlp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_full_method_set,
   input  logic              q_empty,
   input  hrlp_pkg::cls_type q_word,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_kind,
   output logic [7:0]        rsp_path_char,
   output logic [3:0]        rsp_method,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);

   // configuration
   logic                               full_set_ff;
   logic                               full_set_in;

   // parser state
   hrlp_pkg::phase_type                phase_ff;
   hrlp_pkg::phase_type                phase_in;
   logic [hrlp_pkg::NMETH-1:0]         cand_ff;
   logic [hrlp_pkg::NMETH-1:0]         cand_in;
   logic [2:0]                         pos_ff;
   logic [2:0]                         pos_in;
   logic [3:0]                         acc_ff;
   logic [3:0]                         acc_in;
   logic [1:0]                         hex_seen_ff;
   logic [1:0]                         hex_seen_in;
   logic [hrlp_pkg::PLEN_W-1:0]        plen_ff;
   logic [hrlp_pkg::PLEN_W-1:0]        plen_in;
   logic [3:0]                         meth_ff;
   logic [3:0]                         meth_in;

   // output register
   logic                               out_valid_ff;
   logic                               out_valid_in;
   logic                               out_kind_ff;
   logic                               out_kind_in;
   logic [7:0]                         out_char_ff;
   logic [7:0]                         out_char_in;
   logic [3:0]                         out_meth_ff;
   logic [3:0]                         out_meth_in;
   logic [2:0]                         out_status_ff;
   logic [2:0]                         out_status_in;

   // per word working values
   logic                               consume;
   logic                               has_result;
   hrlp_pkg::phase_type                cur_phase;
   logic [hrlp_pkg::NMETH-1:0]         cur_cand;
   logic [2:0]                         cur_pos;
   logic [1:0]                         cur_seen;
   logic [hrlp_pkg::PLEN_W-1:0]        cur_plen;
   logic [3:0]                         cur_meth;
   logic [hrlp_pkg::NMETH-1:0]         next_cand;
   logic [3:0]                         found_meth;
   logic [7:0]                         dec_char;

   // configuration write, always ready
   assign csr_ready   = 1'b1;
   assign full_set_in = (csr_valid && csr_ready) ? csr_full_method_set : full_set_ff;

   // a word is taken when the output register is free or draining
   assign consume = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop   = consume;

   // state seen by this word, restarted on a first byte
   always_comb begin
      cur_phase = phase_ff;
      cur_cand  = cand_ff;
      cur_pos   = pos_ff;
      cur_seen  = hex_seen_ff;
      cur_plen  = plen_ff;
      cur_meth  = meth_ff;
      if (q_word.first) begin
         cur_phase = hrlp_pkg::PH_METHOD;
         cur_cand  = full_set_ff ? hrlp_pkg::CAND_FULL : hrlp_pkg::CAND_BASIC;
         cur_pos   = 3'd0;
         cur_seen  = 2'd0;
         cur_plen  = '0;
         cur_meth  = hrlp_pkg::METH_NONE;
      end
   end

   // method name compare, one lane per method
   always_comb begin
      next_cand  = '0;
      found_meth = cur_meth;
      for (int i = 0; i < hrlp_pkg::NMETH; i++) begin
         if (cur_cand[i] && (cur_pos < hrlp_pkg::METH_LEN[i]) &&
             (hrlp_pkg::meth_char(3'(i), cur_pos) == q_word.data)) begin
            next_cand[i] = 1'b1;
         end
      end
      for (int i = 0; i < hrlp_pkg::NMETH; i++) begin
         if (next_cand[i] &&
             ({1'b0, hrlp_pkg::METH_LEN[i]} == ({1'b0, cur_pos} + 4'd1))) begin
            found_meth = 4'(i + 1);
         end
      end
   end

   // decoded path byte
   always_comb begin
      dec_char = q_word.data;
      if (cur_seen == 2'd2) begin
         dec_char = {acc_ff, q_word.nibble};
      end
   end

   // parser step
   always_comb begin
      phase_in      = phase_ff;
      cand_in       = cand_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      hex_seen_in   = hex_seen_ff;
      plen_in       = plen_ff;
      meth_in       = meth_ff;
      has_result    = 1'b0;
      out_kind_in   = hrlp_pkg::KIND_FINAL;
      out_char_in   = 8'h00;
      out_meth_in   = hrlp_pkg::METH_NONE;
      out_status_in = hrlp_pkg::ST_OK;
      if (consume) begin
         phase_in    = cur_phase;
         cand_in     = cur_cand;
         pos_in      = cur_pos;
         hex_seen_in = cur_seen;
         plen_in     = cur_plen;
         meth_in     = cur_meth;
         if (q_word.first) begin
            acc_in = 4'd0;
         end
         case (cur_phase)
            hrlp_pkg::PH_METHOD: begin
               if (next_cand == '0) begin
                  has_result    = 1'b1;
                  out_status_in = hrlp_pkg::ST_BAD_METH;
               end else begin
                  cand_in = next_cand;
                  pos_in  = cur_pos + 3'd1;
                  meth_in = found_meth;
                  if (found_meth != hrlp_pkg::METH_NONE) begin
                     phase_in = hrlp_pkg::PH_SPACE;
                     if (q_word.last) begin
                        has_result    = 1'b1;
                        out_meth_in   = found_meth;
                        out_status_in = hrlp_pkg::ST_NO_SPACE;
                     end
                  end else if (q_word.last) begin
                     has_result    = 1'b1;
                     out_status_in = hrlp_pkg::ST_BAD_METH;
                  end
               end
            end
            hrlp_pkg::PH_SPACE: begin
               out_meth_in = cur_meth;
               if (!q_word.is_space) begin
                  has_result    = 1'b1;
                  out_status_in = hrlp_pkg::ST_NO_SPACE;
               end else begin
                  phase_in = hrlp_pkg::PH_PATH;
                  if (q_word.last) begin
                     has_result    = 1'b1;
                     out_status_in = hrlp_pkg::ST_NO_END;
                  end
               end
            end
            hrlp_pkg::PH_PATH: begin
               out_meth_in = cur_meth;
               if (q_word.is_space) begin
                  has_result    = 1'b1;
                  out_status_in = hrlp_pkg::ST_OK;
               end else if (q_word.last) begin
                  has_result    = 1'b1;
                  out_status_in = hrlp_pkg::ST_NO_END;
               end else if ((cur_seen == 2'd0) && q_word.is_pct) begin
                  hex_seen_in = 2'd1;
                  acc_in      = 4'd0;
               end else if (cur_seen == 2'd1) begin
                  hex_seen_in = 2'd2;
                  acc_in      = q_word.nibble;
               end else begin
                  hex_seen_in = 2'd0;
                  if (cur_seen != 2'd0) begin
                     acc_in = 4'd0;
                  end
                  has_result = 1'b1;
                  if (cur_plen >= hrlp_pkg::PLEN_W'(hrlp_pkg::PATH_MAX_LEN)) begin
                     out_status_in = hrlp_pkg::ST_TOO_LONG;
                  end else begin
                     plen_in       = cur_plen + 1'b1;
                     out_kind_in   = hrlp_pkg::KIND_CHAR;
                     out_char_in   = dec_char;
                     out_meth_in   = hrlp_pkg::METH_NONE;
                  end
               end
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
         if (has_result && (out_kind_in == hrlp_pkg::KIND_FINAL)) begin
            phase_in = hrlp_pkg::PH_DONE;
         end
      end
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (consume && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         full_set_ff  <= 1'b0;
         phase_ff     <= hrlp_pkg::PH_IDLE;
         cand_ff      <= '0;
         pos_ff       <= 3'd0;
         acc_ff       <= 4'd0;
         hex_seen_ff  <= 2'd0;
         plen_ff      <= '0;
         meth_ff      <= hrlp_pkg::METH_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         full_set_ff  <= full_set_in;
         phase_ff     <= phase_in;
         cand_ff      <= cand_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         hex_seen_ff  <= hex_seen_in;
         plen_ff      <= plen_in;
         meth_ff      <= meth_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (consume && has_result) begin
         out_kind_ff   <= out_kind_in;
         out_char_ff   <= out_char_in;
         out_meth_ff   <= out_meth_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_path_char = out_char_ff;
   assign rsp_method    = out_meth_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last      = out_kind_ff;

   // a final word always leaves the parser done
   a_final_done: assert property (@(posedge clock) disable iff (reset)
      (consume && has_result && (out_kind_in == hrlp_pkg::KIND_FINAL))
      |=> (phase_ff == hrlp_pkg::PH_DONE))
      else $error("final word without done phase");

   // path length stays within the limit
   a_plen_max: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= hrlp_pkg::PLEN_W'(hrlp_pkg::PATH_MAX_LEN))
      else $error("path length over limit");

   // after the method a method code is held
   a_meth_held: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == hrlp_pkg::PH_SPACE) || (phase_ff == hrlp_pkg::PH_PATH))
      |-> (meth_ff != hrlp_pkg::METH_NONE))
      else $error("path phase without method");

   // a held result is not replaced before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |-> !consume)
      else $error("result overwritten while waiting");

endmodule
